[rtl/fbtm_pkg.sv]
// shared types, constants and codes of the frame boundary tag manager
package fbtm_pkg;

	localparam int TABLE_FRAMES = 4096;
	localparam int OWNER_BITS   = 8;
	localparam int ADDR_W       = $clog2(TABLE_FRAMES);
	localparam int FRAMES_W     = 13;
	localparam int TAG_W        = 33;
	localparam int OWN_W        = 2 + OWNER_BITS;

	localparam logic [31:0] NO_MERGE = 32'hFFFF_FFFF;

	// request kinds
	localparam logic [2:0] K_ASSIGN_FRAME = 3'd0;
	localparam logic [2:0] K_ASSIGN_HEAP  = 3'd1;
	localparam logic [2:0] K_CLEAR        = 3'd2;
	localparam logic [2:0] K_MARK         = 3'd3;
	localparam logic [2:0] K_UNMARK       = 3'd4;
	localparam logic [2:0] K_MERGE        = 3'd5;

	// result status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NOT_REGION = 2'd1;
	localparam logic [1:0] ST_PAST_END   = 2'd2;

	// owner classes
	localparam logic [1:0] USE_NONE  = 2'd0;

	// register indexes
	localparam logic REG_BASE   = 1'b0;
	localparam logic REG_FRAMES = 1'b1;

	// table write selects
	localparam logic [3:0] WR_NONE = 4'd0;
	localparam logic [3:0] WR_CLR  = 4'd1;
	localparam logic [3:0] WR_WALK = 4'd2;
	localparam logic [3:0] WR_MK_U = 4'd3;
	localparam logic [3:0] WR_MK_L = 4'd4;
	localparam logic [3:0] WR_MU   = 4'd5;
	localparam logic [3:0] WR_MA   = 4'd6;
	localparam logic [3:0] WR_MN   = 4'd7;
	localparam logic [3:0] WR_MB   = 4'd8;

	// table read selects
	localparam logic [1:0] RD_U = 2'd0;
	localparam logic [1:0] RD_N = 2'd1;
	localparam logic [1:0] RD_A = 2'd2;
	localparam logic [1:0] RD_B = 2'd3;

	typedef struct packed {
		logic [2:0]            kind;
		logic [31:0]           frame_index;
		logic [FRAMES_W-1:0]   count;
		logic [OWNER_BITS-1:0] owner;
		logic                  direction;
	} fbtm_req_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [31:0]           neighbor_begin;
		logic                  entry_side;
		logic [31:0]           entry_other_side;
		logic [1:0]            entry_use;
		logic [OWNER_BITS-1:0] entry_owner;
	} fbtm_rsp_t;

	typedef struct packed {
		logic       load;
		logic [3:0] wr_sel;
		logic [1:0] rd_sel;
		logic       walk_step;
		logic       cap_e;
		logic       ev_u;
		logic       cap_n;
		logic       ev_n;
		logic       cap_a;
		logic       cap_b;
		logic       out_load;
	} fbtm_cmd_t;

	typedef struct packed {
		logic       in_region;
		logic       range_bad;
		logic       cnt_zero;
		logic       cnt_one;
		logic [2:0] kind;
		logic       walk_done;
		logic       clr_done;
		logic       e_ok;
		logic       n_ok;
	} fbtm_stat_t;

endpackage

[rtl/frame_boundary_tag_manager.sv]
// top level of the frame boundary tag manager: config registers, controller and datapath
//
//   channel   signals                          handshake
//   request   start, req                       taken when start & !busy
//   result    done, rsp                        one-cycle strobe, no back-pressure
//   config    psel penable pwrite paddr ...    apb, pready tied high
//
// after reset a clearing pass zeroes the 4096-entry table, one entry a cycle,
// so busy stays high throughout; config writes are taken meanwhile
// assign and clear walk the range at one table write a cycle
// mark and unmark write the end tags, merge rewrites four tags (two table rams,
// one read port each, every read registered)
// the result strobe follows the last table read; the receiver cannot stall it
module frame_boundary_tag_manager (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  fbtm_pkg::fbtm_req_t req,
	output logic                done,
	output fbtm_pkg::fbtm_rsp_t rsp,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [31:0]                   base_q;
	logic [fbtm_pkg::FRAMES_W-1:0] frames_q;
	logic                          cfg_wr;

	fbtm_pkg::fbtm_cmd_t  cmd;
	fbtm_pkg::fbtm_stat_t stat;

	// register index sits at paddr[2], four bytes per register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			frames_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == fbtm_pkg::REG_BASE) begin
				base_q <= pwdata;
			end else begin
				frames_q <= pwdata[fbtm_pkg::FRAMES_W-1:0];
			end
		end
	end

	// read back the raw register contents
	assign prdata = (paddr[2] == fbtm_pkg::REG_FRAMES) ?
		{{(32-fbtm_pkg::FRAMES_W){1'b0}}, frames_q} : base_q;

	// sequencing
	fbtm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	// table, request registers and merge arithmetic
	fbtm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.base       (base_q),
		.frames_cfg (frames_q),
		.cmd        (cmd),
		.stat       (stat),
		.rsp        (rsp)
	);

endmodule

[rtl/fbtm_ram.sv]
// generic single write port ram with registered read
module fbtm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/fbtm_ctrl.sv]
// sequencing state machine of the frame boundary tag manager
module fbtm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	output fbtm_pkg::fbtm_cmd_t cmd,
	input  fbtm_pkg::fbtm_stat_t stat
);

	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_CHK   = 5'd2;
	localparam logic [4:0] S_WALK  = 5'd3;
	localparam logic [4:0] S_MK_U  = 5'd4;
	localparam logic [4:0] S_MK_L  = 5'd5;
	localparam logic [4:0] S_MRD_U = 5'd6;
	localparam logic [4:0] S_MLD_U = 5'd7;
	localparam logic [4:0] S_MEV_U = 5'd8;
	localparam logic [4:0] S_MRD_N = 5'd9;
	localparam logic [4:0] S_MLD_N = 5'd10;
	localparam logic [4:0] S_MEV_N = 5'd11;
	localparam logic [4:0] S_MRD_A = 5'd12;
	localparam logic [4:0] S_MLD_A = 5'd13;
	localparam logic [4:0] S_MRD_B = 5'd14;
	localparam logic [4:0] S_MLD_B = 5'd15;
	localparam logic [4:0] S_MWR_U = 5'd16;
	localparam logic [4:0] S_MWR_A = 5'd17;
	localparam logic [4:0] S_MWR_N = 5'd18;
	localparam logic [4:0] S_MWR_B = 5'd19;
	localparam logic [4:0] S_RRD   = 5'd20;
	localparam logic [4:0] S_ROUT  = 5'd21;

	logic [4:0] state_q, state_d;
	logic       done_q;
	logic       range_kind, owner_kind;

	assign range_kind = (stat.kind <= fbtm_pkg::K_UNMARK);
	assign owner_kind = (stat.kind <= fbtm_pkg::K_CLEAR);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.wr_sel = fbtm_pkg::WR_NONE;
		cmd.rd_sel = fbtm_pkg::RD_U;
		unique case (state_q)
			S_CLR: begin
				cmd.wr_sel = fbtm_pkg::WR_CLR;
				if (stat.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				priority if (!stat.in_region) begin
					state_d = S_ROUT;
				end else if (range_kind && !stat.cnt_zero) begin
					priority if (stat.range_bad) begin
						state_d = S_RRD;
					end else if (owner_kind) begin
						state_d = S_WALK;
					end else begin
						state_d = S_MK_U;
					end
				end else if (stat.kind == fbtm_pkg::K_MERGE) begin
					state_d = S_MRD_U;
				end else begin
					state_d = S_RRD;
				end
			end
			S_WALK: begin
				cmd.wr_sel = fbtm_pkg::WR_WALK;
				cmd.walk_step = 1'b1;
				if (stat.walk_done) begin
					state_d = S_RRD;
				end
			end
			S_MK_U: begin
				cmd.wr_sel = fbtm_pkg::WR_MK_U;
				state_d = stat.cnt_one ? S_RRD : S_MK_L;
			end
			S_MK_L: begin
				cmd.wr_sel = fbtm_pkg::WR_MK_L;
				state_d = S_RRD;
			end
			S_MRD_U: begin
				cmd.rd_sel = fbtm_pkg::RD_U;
				state_d = S_MLD_U;
			end
			S_MLD_U: begin
				cmd.cap_e = 1'b1;
				state_d = S_MEV_U;
			end
			S_MEV_U: begin
				cmd.ev_u = 1'b1;
				state_d = stat.e_ok ? S_MRD_N : S_RRD;
			end
			S_MRD_N: begin
				cmd.rd_sel = fbtm_pkg::RD_N;
				state_d = S_MLD_N;
			end
			S_MLD_N: begin
				cmd.cap_n = 1'b1;
				state_d = S_MEV_N;
			end
			S_MEV_N: begin
				cmd.ev_n = 1'b1;
				state_d = stat.n_ok ? S_MRD_A : S_RRD;
			end
			S_MRD_A: begin
				cmd.rd_sel = fbtm_pkg::RD_A;
				state_d = S_MLD_A;
			end
			S_MLD_A: begin
				cmd.cap_a = 1'b1;
				state_d = S_MRD_B;
			end
			S_MRD_B: begin
				cmd.rd_sel = fbtm_pkg::RD_B;
				state_d = S_MLD_B;
			end
			S_MLD_B: begin
				cmd.cap_b = 1'b1;
				state_d = S_MWR_U;
			end
			S_MWR_U: begin
				cmd.wr_sel = fbtm_pkg::WR_MU;
				state_d = S_MWR_A;
			end
			S_MWR_A: begin
				cmd.wr_sel = fbtm_pkg::WR_MA;
				state_d = S_MWR_N;
			end
			S_MWR_N: begin
				cmd.wr_sel = fbtm_pkg::WR_MN;
				state_d = S_MWR_B;
			end
			S_MWR_B: begin
				cmd.wr_sel = fbtm_pkg::WR_MB;
				state_d = S_RRD;
			end
			S_RRD: begin
				cmd.rd_sel = fbtm_pkg::RD_U;
				state_d = S_ROUT;
			end
			S_ROUT: begin
				cmd.out_load = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == S_ROUT);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

[rtl/fbtm_dp.sv]
// datapath of the frame boundary tag manager: request registers, table and merge math
module fbtm_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fbtm_pkg::fbtm_req_t           req,
	input  logic [31:0]                   base,
	input  logic [fbtm_pkg::FRAMES_W-1:0] frames_cfg,
	input  fbtm_pkg::fbtm_cmd_t           cmd,
	output fbtm_pkg::fbtm_stat_t          stat,
	output fbtm_pkg::fbtm_rsp_t           rsp
);

	localparam int AW = fbtm_pkg::ADDR_W;
	localparam int FW = fbtm_pkg::FRAMES_W;
	localparam int OB = fbtm_pkg::OWNER_BITS;

	fbtm_pkg::fbtm_req_t req_q;
	logic [FW-1:0] frames;
	logic [31:0]   u;
	logic [AW-1:0] u_a;

	logic [AW-1:0] clr_q;
	logic [FW-1:0] walk_q;

	logic          e_side_q, n_side_q, a_side_q, b_side_q;
	logic [31:0]   e_other_q, n_other_q;
	logic [1:0]    e_use_q, n_use_q;
	logic [OB-1:0] e_owner_q, n_owner_q;
	logic          high_q;
	logic [AW-1:0] a_q, n_q, nbo_q;
	logic [31:0]   newa_q, newb_q, nb_q;

	logic [31:0]   a, nbo, new_begin, new_end;
	logic          high, n_valid;
	logic [AW-1:0] n_next;

	logic               tag_we, own_we;
	logic [AW-1:0]      tag_waddr, own_waddr, raddr;
	logic [fbtm_pkg::TAG_W-1:0] tag_wdata, tag_rdata;
	logic [fbtm_pkg::OWN_W-1:0] own_wdata, own_rdata;

	logic mark;

	fbtm_pkg::fbtm_rsp_t rsp_d;

	// effective frame count clamps to the table depth
	assign frames = (frames_cfg > FW'(fbtm_pkg::TABLE_FRAMES)) ?
		FW'(fbtm_pkg::TABLE_FRAMES) : frames_cfg;
	assign u = req_q.frame_index - base;
	assign u_a = u[AW-1:0];
	assign mark = (req_q.kind == fbtm_pkg::K_MARK);

	// status toward the controller
	assign stat.in_region = (u < {{(32-FW){1'b0}}, frames});
	assign stat.range_bad = (({1'b0, u[FW-1:0]} + {1'b0, req_q.count}) > {1'b0, frames});
	assign stat.cnt_zero  = (req_q.count == '0);
	assign stat.cnt_one   = (req_q.count == FW'(1));
	assign stat.kind      = req_q.kind;
	assign stat.walk_done = (walk_q == req_q.count - FW'(1));
	assign stat.clr_done  = (&clr_q);

	// first merge check, on the starting entry
	assign a = e_other_q - base;
	assign high = (e_other_q == req_q.frame_index) ? req_q.direction : (a < u);
	assign n_valid = high ? (({1'b0, u[FW-1:0]} + {{FW{1'b0}}, 1'b1}) < {1'b0, frames})
		: (u_a != '0);
	assign n_next = high ? (u_a + AW'(1)) : (u_a - AW'(1));
	assign stat.e_ok = e_side_q && (a < {{(32-FW){1'b0}}, frames}) && n_valid;

	// second merge check, on the neighbor entry
	assign nbo = n_other_q - base;
	assign stat.n_ok = n_side_q && (n_use_q == e_use_q) && (n_owner_q == e_owner_q) &&
		(nbo < {{(32-FW){1'b0}}, frames}) &&
		(high_q ? (nbo >= {{(32-AW){1'b0}}, n_q}) : (nbo <= {{(32-AW){1'b0}}, n_q}));
	assign new_begin = high_q ? e_other_q : n_other_q;
	assign new_end   = high_q ? n_other_q : e_other_q;

	always_comb begin
		tag_we = 1'b0;
		own_we = 1'b0;
		tag_waddr = u_a;
		own_waddr = u_a;
		tag_wdata = '0;
		own_wdata = '0;
		unique case (cmd.wr_sel)
			fbtm_pkg::WR_NONE: begin
			end
			fbtm_pkg::WR_CLR: begin
				tag_we = 1'b1;
				own_we = 1'b1;
				tag_waddr = clr_q;
				own_waddr = clr_q;
			end
			fbtm_pkg::WR_WALK: begin
				own_we = 1'b1;
				own_waddr = u_a + walk_q[AW-1:0];
				if (req_q.kind != fbtm_pkg::K_CLEAR) begin
					own_wdata = {req_q.kind[1:0] + 2'd1, req_q.owner};
				end
			end
			fbtm_pkg::WR_MK_U: begin
				tag_we = 1'b1;
				tag_wdata = {mark, mark ?
					(req_q.frame_index + {{(32-FW){1'b0}}, req_q.count} - 32'd1) : 32'd0};
			end
			fbtm_pkg::WR_MK_L: begin
				tag_we = 1'b1;
				tag_waddr = u_a + AW'(req_q.count - FW'(1));
				tag_wdata = {mark, mark ? req_q.frame_index : 32'd0};
			end
			fbtm_pkg::WR_MU: begin
				tag_we = 1'b1;
			end
			fbtm_pkg::WR_MA: begin
				tag_we = 1'b1;
				tag_waddr = a_q;
				tag_wdata = {a_side_q, newa_q};
			end
			fbtm_pkg::WR_MN: begin
				tag_we = 1'b1;
				tag_waddr = n_q;
			end
			fbtm_pkg::WR_MB: begin
				tag_we = 1'b1;
				tag_waddr = nbo_q;
				tag_wdata = {b_side_q, newb_q};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		unique case (cmd.rd_sel)
			fbtm_pkg::RD_U: raddr = u_a;
			fbtm_pkg::RD_N: raddr = n_q;
			fbtm_pkg::RD_A: raddr = a_q;
			fbtm_pkg::RD_B: raddr = nbo_q;
			default:        raddr = u_a;
		endcase
	end

	// result word: out of region reports no entry data
	always_comb begin
		rsp_d = '0;
		rsp_d.status = fbtm_pkg::ST_NOT_REGION;
		rsp_d.neighbor_begin = fbtm_pkg::NO_MERGE;
		if (stat.in_region) begin
			rsp_d.status = (req_q.kind <= fbtm_pkg::K_UNMARK && !stat.cnt_zero &&
				stat.range_bad) ? fbtm_pkg::ST_PAST_END : fbtm_pkg::ST_OK;
			rsp_d.neighbor_begin = nb_q;
			{rsp_d.entry_side, rsp_d.entry_other_side} = tag_rdata;
			{rsp_d.entry_use, rsp_d.entry_owner} = own_rdata;
		end
	end

	fbtm_ram #(.WIDTH(fbtm_pkg::TAG_W), .DEPTH(fbtm_pkg::TABLE_FRAMES)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_waddr),
		.wdata (tag_wdata),
		.raddr (raddr),
		.rdata (tag_rdata)
	);

	fbtm_ram #(.WIDTH(fbtm_pkg::OWN_W), .DEPTH(fbtm_pkg::TABLE_FRAMES)) u_own_ram (
		.clk   (clk),
		.we    (own_we),
		.waddr (own_waddr),
		.wdata (own_wdata),
		.raddr (raddr),
		.rdata (own_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.wr_sel == fbtm_pkg::WR_CLR) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
			walk_q <= '0;
			nb_q <= fbtm_pkg::NO_MERGE;
		end
		if (cmd.walk_step) begin
			walk_q <= walk_q + FW'(1);
		end
		if (cmd.cap_e) begin
			{e_side_q, e_other_q} <= tag_rdata;
			{e_use_q, e_owner_q} <= own_rdata;
		end
		if (cmd.ev_u) begin
			high_q <= high;
			a_q <= a[AW-1:0];
			n_q <= n_next;
		end
		if (cmd.cap_n) begin
			{n_side_q, n_other_q} <= tag_rdata;
			{n_use_q, n_owner_q} <= own_rdata;
		end
		if (cmd.ev_n) begin
			nbo_q <= nbo[AW-1:0];
			newa_q <= high_q ? new_end : new_begin;
			newb_q <= high_q ? new_begin : new_end;
			if (stat.n_ok) begin
				nb_q <= high_q ? (base + {{(32-AW){1'b0}}, n_q}) : new_begin;
			end
		end
		if (cmd.cap_a) begin
			a_side_q <= tag_rdata[fbtm_pkg::TAG_W-1];
		end
		if (cmd.cap_b) begin
			b_side_q <= tag_rdata[fbtm_pkg::TAG_W-1];
		end
		if (cmd.out_load) begin
			rsp <= rsp_d;
		end
	end

endmodule

[rtl/fbtm_checker.sv]
// port-level checker for the frame boundary tag manager, bound to the top level
module fbtm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input fbtm_pkg::fbtm_rsp_t rsp
);

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken but block not busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status == fbtm_pkg::ST_OK || rsp.status == fbtm_pkg::ST_NOT_REGION ||
			rsp.status == fbtm_pkg::ST_PAST_END))
		else $error("bad status code");

	a_outside: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == fbtm_pkg::ST_NOT_REGION |->
			rsp.neighbor_begin == fbtm_pkg::NO_MERGE && rsp.entry_use == fbtm_pkg::USE_NONE &&
			!rsp.entry_side)
		else $error("out of region result carries entry data");

endmodule

bind frame_boundary_tag_manager fbtm_checker u_fbtm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
